>>> rtl/prbt_pkg.sv
`default_nettype none
package prbt_pkg;

	localparam logic [2:0] OP_CREATE = 3'd0;
	localparam logic [2:0] OP_READ   = 3'd1;
	localparam logic [2:0] OP_WRITE  = 3'd2;
	localparam logic [2:0] OP_CLOSE  = 3'd3;
	localparam logic [2:0] OP_DUP    = 3'd4;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_FULL        = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND   = 3'd2;
	localparam logic [2:0] ST_WOULD_BLOCK = 3'd3;
	localparam logic [2:0] ST_BROKEN      = 3'd4;
	localparam logic [2:0] ST_BAD_OP      = 3'd5;

	localparam int LANES = 8;
	localparam logic [15:0] REF_MAX = 16'hFFFF;

	typedef struct packed {
		logic load;
		logic exec;
	} ctl_cmd_t;

	typedef struct packed {
		logic done;
	} ctl_stat_t;

endpackage
`default_nettype wire

>>> rtl/pipe_ring_buffer_table_top.sv
// Pipe table: NUM_PIPES byte pipes, each a ring buffer of PIPE_BYTES bytes.
// A request beat (op, handle, length, data_in) is taken at a rising edge
// where start is high and busy is low; busy then stays high until the
// result beat has gone out.
// Each request gives exactly one result beat: status, count, data_out,
// read_end and write_end are valid in the cycle in which done is high.
// A new request is not taken until the result beat has gone out, since
// busy also covers the result cycle. The steps follow the byte store:
// the accepting edge reads a banked row of eight byte lanes and samples
// the request, the edge that ends the exec state updates the counters
// and writes the lanes, and the result is shown in the cycle after that.
// The receiver cannot stall; a result beat is shown for one cycle only.
// Reset clears the slot table and all counters at once; the byte store
// is not cleared, since a read only returns bytes that a write stored.
`default_nettype none
module pipe_ring_buffer_table_top #(
	parameter int NUM_PIPES   = 8,
	parameter int PIPE_BYTES  = 4096,
	parameter int CHUNK_BYTES = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [2:0]  op,
	input  wire  [7:0]  handle,
	input  wire  [3:0]  length,
	input  wire  [63:0] data_in,
	output logic        done,
	output logic [2:0]  status,
	output logic [3:0]  count,
	output logic [63:0] data_out,
	output logic [4:0]  read_end,
	output logic [4:0]  write_end
);

	prbt_pkg::ctl_cmd_t  cmd;
	prbt_pkg::ctl_stat_t stat;

	prbt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .stat(stat)
	);

	prbt_dp #(
		.NUM_PIPES(NUM_PIPES), .PIPE_BYTES(PIPE_BYTES), .CHUNK_BYTES(CHUNK_BYTES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.op(op), .handle(handle), .length(length), .data_in(data_in),
		.done(done), .status(status), .count(count), .data_out(data_out),
		.read_end(read_end), .write_end(write_end)
	);

endmodule
`default_nettype wire

>>> rtl/prbt_ctrl.sv
`default_nettype none
module prbt_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	output prbt_pkg::ctl_cmd_t  cmd,
	input  prbt_pkg::ctl_stat_t stat
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_EXEC;
				S_EXEC: state_q <= S_DONE;
				S_DONE: if (stat.done) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign cmd.load = (state_q == S_IDLE) && start;
	assign cmd.exec = (state_q == S_EXEC);

	a_exec_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec) else $error("exec did not follow load");
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> busy) else $error("busy low after load");
	a_done_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> stat.done) else $error("no result after exec");

endmodule
`default_nettype wire

>>> rtl/prbt_dp.sv
`default_nettype none
module prbt_dp #(
	parameter int NUM_PIPES   = 8,
	parameter int PIPE_BYTES  = 4096,
	parameter int CHUNK_BYTES = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  prbt_pkg::ctl_cmd_t   cmd,
	output prbt_pkg::ctl_stat_t  stat,
	input  wire  [2:0]           op,
	input  wire  [7:0]           handle,
	input  wire  [3:0]           length,
	input  wire  [63:0]          data_in,
	output logic                 done,
	output logic [2:0]           status,
	output logic [3:0]           count,
	output logic [63:0]          data_out,
	output logic [4:0]           read_end,
	output logic [4:0]           write_end
);

	localparam int SW = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
	localparam int PW = $clog2(PIPE_BYTES);
	localparam int FW = PW + 1;
	localparam int LB = 3;
	localparam int RW = PW - LB;
	localparam int DEPTH = NUM_PIPES * (PIPE_BYTES / prbt_pkg::LANES);
	localparam int AW = $clog2(DEPTH);

	logic [NUM_PIPES-1:0] used_q;
	logic [PW-1:0] head_q [NUM_PIPES];
	logic [FW-1:0] fill_q [NUM_PIPES];
	logic [15:0]   rref_q [NUM_PIPES];
	logic [15:0]   wref_q [NUM_PIPES];

	logic [7:0] mem0 [DEPTH];
	logic [7:0] mem1 [DEPTH];
	logic [7:0] mem2 [DEPTH];
	logic [7:0] mem3 [DEPTH];
	logic [7:0] mem4 [DEPTH];
	logic [7:0] mem5 [DEPTH];
	logic [7:0] mem6 [DEPTH];
	logic [7:0] mem7 [DEPTH];

	logic [2:0]  op_q;
	logic [3:0]  len_q;
	logic [63:0] din_q;
	logic [SW-1:0] slot_q;
	logic          wr_q;
	logic          hit_q;
	logic [PW-1:0] pos_q;
	logic [63:0]   rdata_q;

	logic [7:0]    raw;
	logic [6:0]    sraw;
	logic          hit;
	logic [SW-1:0] slot;
	logic [3:0]    lenc;
	logic [PW-1:0] pos;
	logic [AW-1:0] addr [prbt_pkg::LANES];
	logic [RW-1:0] row;
	logic [63:0]   rdata;

	always_comb begin
		raw  = handle - 8'd1;
		sraw = raw[7:1];
		slot = sraw[SW-1:0];
		hit  = (handle != 8'd0) && ({25'd0, sraw} < NUM_PIPES) && used_q[slot];
		lenc = (length > 4'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES) : length;
		if (op == prbt_pkg::OP_WRITE)
			pos = head_q[slot] + fill_q[slot][PW-1:0];
		else
			pos = head_q[slot];
		for (int l = 0; l < prbt_pkg::LANES; l++) begin
			row = pos[PW-1:LB] + ((3'(l) < pos[2:0]) ? RW'(1) : RW'(0));
			addr[l] = AW'({slot, row});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rdata_q[7:0]   <= mem0[addr[0]];
			rdata_q[15:8]  <= mem1[addr[1]];
			rdata_q[23:16] <= mem2[addr[2]];
			rdata_q[31:24] <= mem3[addr[3]];
			rdata_q[39:32] <= mem4[addr[4]];
			rdata_q[47:40] <= mem5[addr[5]];
			rdata_q[55:48] <= mem6[addr[6]];
			rdata_q[63:56] <= mem7[addr[7]];
			op_q  <= op;
			len_q <= lenc;
			din_q <= data_in;
			slot_q <= slot;
			wr_q  <= raw[0];
			hit_q <= hit;
			pos_q <= pos;
		end
	end

	logic [FW-1:0] room, n;
	logic [63:0]   wsh;
	logic [7:0]    wen;
	logic [2:0]    st;
	logic [3:0]    cnt;
	logic [63:0]   dout;
	logic [SW-1:0] fslot;
	logic          ffound;
	logic          do_rd, do_wr;

	always_comb begin
		room = FW'(PIPE_BYTES) - fill_q[slot_q];
		st = prbt_pkg::ST_OK;
		n = '0;
		do_rd = 1'b0;
		do_wr = 1'b0;
		fslot = '0;
		ffound = 1'b0;
		for (int i = NUM_PIPES - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				fslot = SW'(i);
				ffound = 1'b1;
			end
		end
		unique case (op_q)
			prbt_pkg::OP_CREATE: if (!ffound) st = prbt_pkg::ST_FULL;
			prbt_pkg::OP_READ: begin
				if (!hit_q || wr_q)
					st = prbt_pkg::ST_NOT_FOUND;
				else if (fill_q[slot_q] == '0)
					st = (wref_q[slot_q] == 16'd0) ? prbt_pkg::ST_OK
						: prbt_pkg::ST_WOULD_BLOCK;
				else begin
					n = (FW'(len_q) < fill_q[slot_q]) ? FW'(len_q) : fill_q[slot_q];
					do_rd = 1'b1;
				end
			end
			prbt_pkg::OP_WRITE: begin
				if (!hit_q || !wr_q)
					st = prbt_pkg::ST_NOT_FOUND;
				else if (rref_q[slot_q] == 16'd0)
					st = prbt_pkg::ST_BROKEN;
				else if (room == '0)
					st = prbt_pkg::ST_WOULD_BLOCK;
				else begin
					n = (FW'(len_q) < room) ? FW'(len_q) : room;
					do_wr = 1'b1;
				end
			end
			prbt_pkg::OP_CLOSE, prbt_pkg::OP_DUP:
				if (!hit_q) st = prbt_pkg::ST_NOT_FOUND;
			default: st = prbt_pkg::ST_BAD_OP;
		endcase
		cnt = n[3:0];
		rdata = (rdata_q >> {pos_q[2:0], 3'd0}) | (rdata_q << {3'd0 - pos_q[2:0], 3'd0});
		if (pos_q[2:0] == 3'd0)
			rdata = rdata_q;
		dout = '0;
		for (int b = 0; b < prbt_pkg::LANES; b++)
			if (do_rd && (4'(b) < cnt))
				dout[b*8 +: 8] = rdata[b*8 +: 8];
		wsh = (din_q << {pos_q[2:0], 3'd0}) | (din_q >> {3'd0 - pos_q[2:0], 3'd0});
		if (pos_q[2:0] == 3'd0)
			wsh = din_q;
		for (int l = 0; l < prbt_pkg::LANES; l++)
			wen[l] = do_wr && ((3'(l) - pos_q[2:0]) < cnt[2:0] || cnt[3]);
	end

	logic [AW-1:0] waddr [prbt_pkg::LANES];
	always_comb begin
		for (int l = 0; l < prbt_pkg::LANES; l++)
			waddr[l] = AW'({slot_q, pos_q[PW-1:LB] +
				((3'(l) < pos_q[2:0]) ? RW'(1) : RW'(0))});
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (wen[0]) mem0[waddr[0]] <= wsh[7:0];
			if (wen[1]) mem1[waddr[1]] <= wsh[15:8];
			if (wen[2]) mem2[waddr[2]] <= wsh[23:16];
			if (wen[3]) mem3[waddr[3]] <= wsh[31:24];
			if (wen[4]) mem4[waddr[4]] <= wsh[39:32];
			if (wen[5]) mem5[waddr[5]] <= wsh[47:40];
			if (wen[6]) mem6[waddr[6]] <= wsh[55:48];
			if (wen[7]) mem7[waddr[7]] <= wsh[63:56];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			done <= 1'b0;
			for (int i = 0; i < NUM_PIPES; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
				rref_q[i] <= '0;
				wref_q[i] <= '0;
			end
		end else begin
			done <= cmd.exec;
			if (cmd.exec) begin
				if (op_q == prbt_pkg::OP_CREATE && ffound) begin
					used_q[fslot] <= 1'b1;
					head_q[fslot] <= '0;
					fill_q[fslot] <= '0;
					rref_q[fslot] <= 16'd1;
					wref_q[fslot] <= 16'd1;
				end
				if (do_rd) begin
					head_q[slot_q] <= head_q[slot_q] + n[PW-1:0];
					fill_q[slot_q] <= fill_q[slot_q] - n;
				end
				if (do_wr)
					fill_q[slot_q] <= fill_q[slot_q] + n;
				if (op_q == prbt_pkg::OP_CLOSE && hit_q) begin
					if (wr_q) begin
						if (wref_q[slot_q] != 16'd0)
							wref_q[slot_q] <= wref_q[slot_q] - 16'd1;
						if (rref_q[slot_q] == 16'd0 && wref_q[slot_q] <= 16'd1)
							used_q[slot_q] <= 1'b0;
					end else begin
						if (rref_q[slot_q] != 16'd0)
							rref_q[slot_q] <= rref_q[slot_q] - 16'd1;
						if (wref_q[slot_q] == 16'd0 && rref_q[slot_q] <= 16'd1)
							used_q[slot_q] <= 1'b0;
					end
				end
				if (op_q == prbt_pkg::OP_DUP && hit_q) begin
					if (wr_q) begin
						if (wref_q[slot_q] != prbt_pkg::REF_MAX)
							wref_q[slot_q] <= wref_q[slot_q] + 16'd1;
					end else if (rref_q[slot_q] != prbt_pkg::REF_MAX)
						rref_q[slot_q] <= rref_q[slot_q] + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status <= st;
			count <= cnt;
			data_out <= dout;
			if (op_q == prbt_pkg::OP_CREATE && ffound) begin
				read_end  <= 5'({fslot, 1'b0}) + 5'd1;
				write_end <= 5'({fslot, 1'b0}) + 5'd2;
			end else begin
				read_end  <= '0;
				write_end <= '0;
			end
		end
	end

	assign stat.done = done;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && do_wr |-> (fill_q[slot_q] + n) <= FW'(PIPE_BYTES))
		else $error("fill overflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> cnt <= 4'(CHUNK_BYTES)) else $error("count too large");
	a_rw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !(do_rd && do_wr)) else $error("read and write together");

endmodule
`default_nettype wire

>>> bench/pipe_table_checker.sv
`timescale 1ns / 100ps
module pipe_table_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire         busy,
	input  wire  [2:0]  op,
	input  wire  [7:0]  handle,
	input  wire  [3:0]  length,
	input  wire  [63:0] data_in,
	input  wire         done,
	input  wire  [2:0]  status,
	input  wire  [3:0]  count,
	input  wire  [63:0] data_out,
	input  wire  [4:0]  read_end,
	input  wire  [4:0]  write_end,
	output int          errors,
	output int          pending,
	output int          beats_seen
);

	localparam int NP = 8;
	localparam int PB = 4096;

	typedef struct packed {
		logic [2:0]  st;
		logic [3:0]  cnt;
		logic [63:0] dat;
		logic [4:0]  rend;
		logic [4:0]  wend;
	} reply_t;

	logic        used [NP];
	logic [11:0] head [NP];
	logic [12:0] fill [NP];
	logic [15:0] rrefs [NP];
	logic [15:0] wrefs [NP];
	logic [7:0]  bytes [NP*PB];
	reply_t      replies_due [$];

	function automatic reply_t model_request(logic [2:0] o, logic [7:0] h, logic [3:0] l,
			logic [63:0] d);
		reply_t r;
		int s, n, len, pos;
		logic wr, ok;
		r = '0;
		len = (l > 4'd8) ? 8 : int'(l);
		ok = (h != 8'd0) && (int'((h - 8'd1) >> 1) < NP);
		s = ok ? int'((h - 8'd1) >> 1) : 0;
		wr = ~h[0];
		ok = ok && used[s];
		case (o)
		prbt_pkg::OP_CREATE: begin
			r.st = prbt_pkg::ST_FULL;
			for (int i = 0; i < NP; i++) if (!used[i]) begin
				used[i] = 1'b1; head[i] = '0; fill[i] = '0; rrefs[i] = 16'd1; wrefs[i] = 16'd1;
				r.rend = 5'(i*2 + 1); r.wend = 5'(i*2 + 2); r.st = prbt_pkg::ST_OK;
				break;
			end
		end
		prbt_pkg::OP_READ: begin
			if (!ok || wr) r.st = prbt_pkg::ST_NOT_FOUND;
			else if (fill[s] == 0)
				r.st = (wrefs[s] == 0) ? prbt_pkg::ST_OK : prbt_pkg::ST_WOULD_BLOCK;
			else begin
				n = (len < fill[s]) ? len : int'(fill[s]);
				for (int i = 0; i < n; i++) begin
					pos = (head[s] + i) % PB;
					r.dat[8*i +: 8] = bytes[s*PB + pos];
				end
				head[s] = 12'((head[s] + n) % PB);
				fill[s] = 13'(fill[s] - n);
				r.cnt = 4'(n);
			end
		end
		prbt_pkg::OP_WRITE: begin
			if (!ok || !wr) r.st = prbt_pkg::ST_NOT_FOUND;
			else if (rrefs[s] == 0) r.st = prbt_pkg::ST_BROKEN;
			else if (fill[s] == PB) r.st = prbt_pkg::ST_WOULD_BLOCK;
			else begin
				n = (len < PB - fill[s]) ? len : PB - fill[s];
				for (int i = 0; i < n; i++) begin
					pos = (head[s] + fill[s] + i) % PB;
					bytes[s*PB + pos] = d[8*i +: 8];
				end
				fill[s] = 13'(fill[s] + n);
				r.cnt = 4'(n);
			end
		end
		prbt_pkg::OP_CLOSE: begin
			if (!ok) r.st = prbt_pkg::ST_NOT_FOUND;
			else begin
				if (wr) begin
					if (wrefs[s] > 0) wrefs[s]--;
				end else if (rrefs[s] > 0) rrefs[s]--;
				if (rrefs[s] == 0 && wrefs[s] == 0) used[s] = 1'b0;
			end
		end
		prbt_pkg::OP_DUP: begin
			if (!ok) r.st = prbt_pkg::ST_NOT_FOUND;
			else if (wr) begin
				if (wrefs[s] < prbt_pkg::REF_MAX) wrefs[s]++;
			end else if (rrefs[s] < prbt_pkg::REF_MAX) rrefs[s]++;
		end
		default: r.st = prbt_pkg::ST_BAD_OP;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		reply_t want;
		if (!arst_n) begin
			errors = 0;
			beats_seen = 0;
			replies_due.delete();
			for (int i = 0; i < NP; i++) begin
				used[i] = 1'b0; head[i] = '0; fill[i] = '0; rrefs[i] = '0; wrefs[i] = '0;
			end
		end else begin
			if (done) begin
				beats_seen++;
				if (replies_due.size() == 0) begin
					$display("%0t: result beat with none due: st=%0d cnt=%0d", $time, status,
						count);
					errors++;
				end else begin
					want = replies_due.pop_front();
					if (want.st != status) begin
						$display("%0t: status exp %0d got %0d", $time, want.st, status);
						errors++;
					end
					if (want.cnt != count) begin
						$display("%0t: count exp %0d got %0d", $time, want.cnt, count);
						errors++;
					end
					if (want.dat != data_out) begin
						$display("%0t: data_out exp %h got %h", $time, want.dat, data_out);
						errors++;
					end
					if (want.rend != read_end) begin
						$display("%0t: read_end exp %0d got %0d", $time, want.rend, read_end);
						errors++;
					end
					if (want.wend != write_end) begin
						$display("%0t: write_end exp %0d got %0d", $time, want.wend,
							write_end);
						errors++;
					end
				end
			end
			if (start && !busy)
				replies_due.push_back(model_request(op, handle, length, data_in));
		end
		pending = replies_due.size();
	end

endmodule

>>> bench/pipe_ring_buffer_table_top_test.sv
`timescale 1ns / 100ps
module pipe_ring_buffer_table_top_test;

	logic        clk, arst_n, start;
	logic [2:0]  op;
	logic [7:0]  handle;
	logic [3:0]  length;
	logic [63:0] data_in;
	wire         busy, done;
	wire  [2:0]  status;
	wire  [3:0]  count;
	wire  [63:0] data_out;
	wire  [4:0]  read_end, write_end;
	int          errors, pending, beats_seen;
	int          cycles = 0;
	int          sent;

	pipe_ring_buffer_table_top dut (.*);
	pipe_table_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("pipe_ring_buffer_table_top: mismatch");
			$finish;
		end
	end

	// One request beat; holds start until the block takes it.
	task automatic send(logic [2:0] o, logic [7:0] h, logic [3:0] l, logic [63:0] d);
		start <= 1'b1; op <= o; handle <= h; length <= l; data_in <= d;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_end(logic wr);
		int s;
		s = $urandom_range(0, 7);
		if ($urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
		return 8'(s*2 + int'(wr) + 1);
	endfunction

	initial begin
		int burst, k;
		logic [2:0] o;
		arst_n = 0; start = 0; op = '0; handle = '0; length = '0; data_in = '0; sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send(prbt_pkg::OP_READ, 8'd1, 4'd8, '0);
		send(prbt_pkg::OP_WRITE, 8'd0, 4'd8, '1);
		send(prbt_pkg::OP_CREATE, '0, '0, '0);
		send(prbt_pkg::OP_WRITE, 8'd2, 4'd15, 64'h0123_4567_89AB_CDEF);
		send(prbt_pkg::OP_WRITE, 8'd1, 4'd8, '1);
		send(prbt_pkg::OP_READ, 8'd2, 4'd8, '0);
		send(prbt_pkg::OP_READ, 8'd1, 4'd0, '0);
		send(prbt_pkg::OP_WRITE, 8'd2, 4'd0, '1);
		send(prbt_pkg::OP_READ, 8'd1, 4'd3, '0);
		send(prbt_pkg::OP_READ, 8'd1, 4'd15, '0);
		send(prbt_pkg::OP_READ, 8'd1, 4'd8, '0);
		send(prbt_pkg::OP_DUP, 8'd2, '0, '0);
		send(prbt_pkg::OP_DUP, 8'd255, '0, '0);
		send(3'd5, '0, '0, '0);
		send(3'd7, 8'd1, 4'd8, '1);
		send(prbt_pkg::OP_CLOSE, 8'd2, '0, '0);
		send(prbt_pkg::OP_CLOSE, 8'd2, '0, '0);
		send(prbt_pkg::OP_CLOSE, 8'd2, '0, '0);
		send(prbt_pkg::OP_READ, 8'd1, 4'd8, '0);
		send(prbt_pkg::OP_CLOSE, 8'd1, '0, '0);
		send(prbt_pkg::OP_CLOSE, 8'd1, '0, '0);
		for (int i = 0; i < 9; i++) send(prbt_pkg::OP_CREATE, '0, '0, '0);
		send(prbt_pkg::OP_CLOSE, 8'd1, '0, '0);
		send(prbt_pkg::OP_WRITE, 8'd2, 4'd8, '1);
		send(prbt_pkg::OP_CLOSE, 8'd17, '0, '0);
		// Fill one pipe to the brim, then drain it across the wrap.
		for (int i = 0; i < 513; i++)
			send(prbt_pkg::OP_WRITE, 8'd4, 4'd8, {$urandom, $urandom});
		send(prbt_pkg::OP_READ, 8'd3, 4'd5, '0);
		send(prbt_pkg::OP_WRITE, 8'd4, 4'd8, {$urandom, $urandom});
		for (int i = 0; i < 513; i++) send(prbt_pkg::OP_READ, 8'd3, 4'd8, '0);
		while (sent < 1700) begin
			burst = $urandom_range(1, 30);
			for (int b = 0; b < burst; b++) begin
				k = $urandom_range(0, 99);
				if (k < 4) o = prbt_pkg::OP_CREATE;
				else if (k < 45) o = prbt_pkg::OP_WRITE;
				else if (k < 88) o = prbt_pkg::OP_READ;
				else if (k < 94) o = prbt_pkg::OP_CLOSE;
				else if (k < 98) o = prbt_pkg::OP_DUP;
				else o = 3'($urandom_range(5, 7));
				send(o, pick_end(o == prbt_pkg::OP_WRITE ? 1'b1 :
					o == prbt_pkg::OP_READ ? 1'b0 : 1'($urandom)),
					4'($urandom_range(0, 15)), {$urandom, $urandom});
			end
			if ($urandom_range(0, 2) != 0) pause($urandom_range(0, 12));
		end
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Ran %0d requests over all ops, both ends and a full-pipe wrap;", sent);
		$display("%0d result beats checked.", beats_seen);
		if (errors == 0)
			$display("pipe_ring_buffer_table_top: match");
		else
			$display("pipe_ring_buffer_table_top: mismatch");
		$finish;
	end

endmodule
